// ----- hdl/speaker_pan_coefficients_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Speaker pan coefficients: assertion macros
// Shared concurrent checks, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPEAKER_PAN_COEFFICIENTS_UNIT_DEFINES_SVH
`define SPEAKER_PAN_COEFFICIENTS_UNIT_DEFINES_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, constants and tables of the speaker pan coefficients unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spc_pkg;
	localparam int CORDIC_BITS  = 20;
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_W     = 38;
	localparam int ACC_W        = 29;
	localparam int SPK_COUNT    = 15;
	localparam int OUT_COUNT    = 7;
	localparam int POS_W        = 16;
	localparam int WIDTH_W      = 15;
	localparam int GAIN_W       = 16;

	localparam int SPK_DEG [SPK_COUNT] = '{
		-360, -330, -270, -210, -150, -90, -30, 0, 30, 90, 150, 210, 270, 330, 360
	};
	// output slot of each speaker: ch0, ch1, ch2, ch4, ch5, ch6, ch7
	localparam int SPK_OUT [SPK_COUNT] = '{
		2, 1, 4, 6, 5, 3, 0, 2, 1, 4, 6, 5, 3, 0, 2
	};

	typedef logic [1:0] lane_kind_t;
	localparam lane_kind_t KIND_NONE  = 2'd0;
	localparam lane_kind_t KIND_UNITY = 2'd1;
	localparam lane_kind_t KIND_RAMP  = 2'd2;

	typedef struct packed {
		logic                 x_zero;
		logic                 z_neg;
		logic                 base_neg;
		logic [WIDTH_W-1:0]   inner_width;
		logic [WIDTH_W-1:0]   outer_width;
	} side_t;

	// arctangent of 2^-idx in degree * 2^20
	function automatic logic [ACC_W-2:0] atan_const(input int idx);
		logic [ACC_W-2:0] v;
		case (idx)
			0:       v = 28'd47185920;
			1:       v = 28'd27855475;
			2:       v = 28'd14718068;
			3:       v = 28'd7471121;
			4:       v = 28'd3750058;
			5:       v = 28'd1876857;
			6:       v = 28'd938658;
			7:       v = 28'd469357;
			8:       v = 28'd234682;
			9:       v = 28'd117342;
			10:      v = 28'd58671;
			11:      v = 28'd29335;
			12:      v = 28'd14668;
			13:      v = 28'd7334;
			14:      v = 28'd3667;
			15:      v = 28'd1833;
			16:      v = 28'd917;
			17:      v = 28'd458;
			18:      v = 28'd229;
			19:      v = 28'd115;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

// ----- hdl/spc_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// spc_cordic_cell
// One vectoring rotation of the bearing chain, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_cordic_cell import spc_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic signed [CORDIC_W-1:0] re_i,
	input  logic signed [CORDIC_W-1:0] im_i,
	input  logic signed [ACC_W-1:0]    acc_i,
	input  side_t                      side_i,
	output logic                       vld_q,
	output logic signed [CORDIC_W-1:0] re_q,
	output logic signed [CORDIC_W-1:0] im_q,
	output logic signed [ACC_W-1:0]    acc_q,
	output side_t                      side_q
);
	logic signed [CORDIC_W-1:0] dr;
	logic signed [CORDIC_W-1:0] di;
	logic signed [ACC_W-1:0]    ang;

	assign dr  = im_i >>> IDX;
	assign di  = re_i >>> IDX;
	assign ang = $signed({1'b0, atan_const(IDX)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!im_i[CORDIC_W-1]) begin
				re_q  <= re_i + dr;
				im_q  <= im_i - di;
				acc_q <= acc_i + ang;
			end else begin
				re_q  <= re_i - dr;
				im_q  <= im_i + di;
				acc_q <= acc_i - ang;
			end
			side_q <= side_i;
		end
	end
endmodule

// ----- hdl/spc_window.sv -----
// ----------------------------------------------------------------------------
// spc_window
// Bearing rounding, window edges with truncating wrap, and per-speaker
// ramp setup (numerator, divisor, lane kind).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_window import spc_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int GAIN_FRAC_BITS  = 15,
	parameter int NW              = ANGLE_FRAC_BITS + 12,
	parameter int DW              = NW + GAIN_FRAC_BITS + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic signed [ACC_W-1:0] acc_i,
	input  side_t                   side_i,
	output logic                    vld_q,
	output lane_kind_t              kind_q [SPK_COUNT],
	output logic [DW-1:0]           dvd_q  [SPK_COUNT],
	output logic [NW-1:0]           den_q  [SPK_COUNT]
);
	localparam int EW      = NW;
	localparam int TW      = ACC_W + 2;
	localparam int SH      = CORDIC_BITS - ANGLE_FRAC_BITS;
	localparam int HALF    = 2 ** (SH - 1);
	localparam int BASE_P  = 180 * (2 ** CORDIC_BITS) + HALF;
	localparam int BASE_M  = -180 * (2 ** CORDIC_BITS) + HALF;
	localparam int REAR    = 180 * (2 ** ANGLE_FRAC_BITS);
	localparam int FULL    = 360 * (2 ** (ANGLE_FRAC_BITS + 1));
	localparam int K       = $clog2(32768 / FULL + 2);
	localparam int MS      = K + 1;
	localparam int MW      = $clog2(FULL * (2 ** (K + 1)));

	// stage 1: rounded bearing, doubled
	logic signed [TW-1:0] addend;
	logic signed [TW-1:0] total;
	logic signed [EW-1:0] bear;
	logic                 vld_s1;
	logic signed [EW-1:0] a_s1;
	logic [WIDTH_W-1:0]   iw_s1;
	logic [WIDTH_W-1:0]   ow_s1;

	always_comb begin
		if (!side_i.z_neg) begin
			addend = TW'(HALF);
		end else if (side_i.base_neg) begin
			addend = TW'(BASE_M);
		end else begin
			addend = TW'(BASE_P);
		end
		total = TW'(acc_i) + addend;
		if (side_i.x_zero) begin
			bear = side_i.z_neg ? EW'(REAR) : '0;
		end else begin
			bear = EW'(total >>> SH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= {bear[EW-2:0], 1'b0};
			iw_s1 <= side_i.inner_width;
			ow_s1 <= side_i.outer_width;
		end
	end

	// stage 2: raw edges as sign and magnitude (outer left, outer right,
	// inner left, inner right)
	logic signed [MW:0]   raw [4];
	logic                 mod_vld_q [MS+1];
	logic [MW-1:0]        mod_mag_q [MS+1][4];
	logic                 mod_sgn_q [MS+1][4];
	logic signed [EW-1:0] mod_a_q   [MS+1];

	always_comb begin
		raw[0] = (MW+1)'(a_s1) - $signed({1'b0, (MW)'(ow_s1)});
		raw[1] = (MW+1)'(a_s1) + $signed({1'b0, (MW)'(ow_s1)});
		raw[2] = (MW+1)'(a_s1) - $signed({1'b0, (MW)'(iw_s1)});
		raw[3] = (MW+1)'(a_s1) + $signed({1'b0, (MW)'(iw_s1)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_vld_q[0] <= 1'b0;
		end else if (en) begin
			mod_vld_q[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 4; e++) begin
				mod_sgn_q[0][e] <= raw[e][MW];
				mod_mag_q[0][e] <= raw[e][MW] ? MW'(-raw[e]) : MW'(raw[e]);
			end
			mod_a_q[0] <= a_s1;
		end
	end

	// wrap stages: one multiple of the full circle per stage
	for (genvar st = 0; st < MS; st++) begin : g_mod
		localparam int SUBV = FULL * (2 ** (K - st));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mod_vld_q[st+1] <= 1'b0;
			end else if (en) begin
				mod_vld_q[st+1] <= mod_vld_q[st];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int e = 0; e < 4; e++) begin
					if (mod_mag_q[st][e] >= MW'(SUBV)) begin
						mod_mag_q[st+1][e] <= mod_mag_q[st][e] - MW'(SUBV);
					end else begin
						mod_mag_q[st+1][e] <= mod_mag_q[st][e];
					end
					mod_sgn_q[st+1][e] <= mod_sgn_q[st][e];
				end
				mod_a_q[st+1] <= mod_a_q[st];
			end
		end
	end

	// stage 3: signed edges
	logic                 vld_s3;
	logic signed [EW-1:0] edge_s3 [4];
	logic signed [EW-1:0] a_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= mod_vld_q[MS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 4; e++) begin
				edge_s3[e] <= mod_sgn_q[MS][e] ? -EW'(mod_mag_q[MS][e]) :
					EW'(mod_mag_q[MS][e]);
			end
			a_s3 <= mod_a_q[MS];
		end
	end

	// stages 4 to 6, one lane per speaker
	logic vld_s4;
	logic vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_q  <= vld_s5;
		end
	end

	for (genvar l = 0; l < SPK_COUNT; l++) begin : g_lane
		localparam logic signed [EW-1:0] SPOS =
			EW'(SPK_DEG[l] * (2 ** (ANGLE_FRAC_BITS + 1)));

		logic                 left;
		logic signed [EW-1:0] o_edge;
		logic signed [EW-1:0] n_edge;
		logic                 outer_s4;
		logic                 inner_s4;
		logic signed [EW:0]   dos_s4;
		logic signed [EW:0]   don_s4;
		lane_kind_t           kind_s5;
		logic [NW-1:0]        num_s5;
		logic [NW-1:0]        den_s5;

		assign left   = SPOS < a_s3;
		assign o_edge = left ? edge_s3[0] : edge_s3[1];
		assign n_edge = left ? edge_s3[2] : edge_s3[3];

		always_ff @(posedge clk) begin
			if (en) begin
				outer_s4 <= (SPOS > edge_s3[0]) && (edge_s3[1] > SPOS);
				inner_s4 <= (SPOS > edge_s3[2]) && (edge_s3[3] > SPOS);
				dos_s4   <= (EW+1)'(o_edge) - (EW+1)'(SPOS);
				don_s4   <= (EW+1)'(o_edge) - (EW+1)'(n_edge);

				num_s5 <= dos_s4[EW] ? NW'(-dos_s4) : NW'(dos_s4);
				den_s5 <= don_s4[EW] ? NW'(-don_s4) : NW'(don_s4);
				if (!outer_s4) begin
					kind_s5 <= KIND_NONE;
				end else if (inner_s4 || don_s4 == '0) begin
					kind_s5 <= KIND_UNITY;
				end else begin
					kind_s5 <= KIND_RAMP;
				end

				if (kind_s5 == KIND_RAMP && num_s5 >= den_s5) begin
					kind_q[l] <= KIND_UNITY;
				end else begin
					kind_q[l] <= kind_s5;
				end
				dvd_q[l] <= DW'({num_s5, {GAIN_FRAC_BITS{1'b0}}}) + DW'(den_s5 >> 1);
				den_q[l] <= den_s5;
			end
		end
	end
endmodule

// ----- hdl/spc_div_cell.sv -----
// ----------------------------------------------------------------------------
// spc_div_cell
// One restoring quotient bit for every speaker lane, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_div_cell import spc_pkg::*; #(
	parameter int NW  = 18,
	parameter int DW  = 34,
	parameter int QW  = 16,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  lane_kind_t    kind_i [SPK_COUNT],
	input  logic [DW-1:0] rem_i  [SPK_COUNT],
	input  logic [NW-1:0] den_i  [SPK_COUNT],
	input  logic [QW-1:0] quo_i  [SPK_COUNT],
	output logic          vld_q,
	output lane_kind_t    kind_q [SPK_COUNT],
	output logic [DW-1:0] rem_q  [SPK_COUNT],
	output logic [NW-1:0] den_q  [SPK_COUNT],
	output logic [QW-1:0] quo_q  [SPK_COUNT]
);
	logic [DW-1:0] sub [SPK_COUNT];

	always_comb begin
		for (int l = 0; l < SPK_COUNT; l++) begin
			sub[l] = DW'(den_i[l]) << BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < SPK_COUNT; l++) begin
				if (rem_i[l] >= sub[l]) begin
					rem_q[l] <= rem_i[l] - sub[l];
					quo_q[l] <= quo_i[l] | (QW'(1) << BIT);
				end else begin
					rem_q[l] <= rem_i[l];
					quo_q[l] <= quo_i[l];
				end
				kind_q[l] <= kind_i[l];
				den_q[l]  <= den_i[l];
			end
		end
	end
endmodule

// ----- hdl/speaker_pan_coefficients_unit.sv -----
// ----------------------------------------------------------------------------
// speaker_pan_coefficients_unit
// Angular panning of one source position onto seven speaker channels.
// ----------------------------------------------------------------------------
//  channel | signals                                      | dir
//  pos     | pos_valid, pos_stall, local_x, local_z,      | in
//          | inner_width, outer_width                     |
//  gain    | gain_valid, gain_stall, gain_front_left ..   | out
//          | gain_chan_seven                              |
//
// One item per cycle while gain_stall does not hold a result. K + 1 is the
// number of circle-wrap stages (K = 1 at the default angle format). Stages:
// 20 bearing cells, the window stages and one divider cell per gain bit.
// Reset clears every stage valid; no payload is reset.
// A stalled result freezes the whole pipeline; pos_stall follows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "speaker_pan_coefficients_unit_defines.svh"

module speaker_pan_coefficients_unit import spc_pkg::*; #(
	parameter int GAIN_FRAC_BITS  = 15,
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pos_valid,
	output logic                    pos_stall,
	input  logic signed [POS_W-1:0] local_x,
	input  logic signed [POS_W-1:0] local_z,
	input  logic [WIDTH_W-1:0]      inner_width,
	input  logic [WIDTH_W-1:0]      outer_width,
	output logic                    gain_valid,
	input  logic                    gain_stall,
	output logic [GAIN_W-1:0]       gain_front_left,
	output logic [GAIN_W-1:0]       gain_front_right,
	output logic [GAIN_W-1:0]       gain_center,
	output logic [GAIN_W-1:0]       gain_chan_four,
	output logic [GAIN_W-1:0]       gain_chan_five,
	output logic [GAIN_W-1:0]       gain_chan_six,
	output logic [GAIN_W-1:0]       gain_chan_seven
);
	localparam int NW = ANGLE_FRAC_BITS + 12;
	localparam int DW = NW + GAIN_FRAC_BITS + 1;
	localparam int QW = GAIN_FRAC_BITS + 1;
	localparam int GW = GAIN_FRAC_BITS + 1;
	localparam logic [GW-1:0] UNITY = GW'(1) << GAIN_FRAC_BITS;

	logic en;
	logic out_vld_q;

	assign en         = !(out_vld_q && gain_stall);
	assign pos_stall  = !en;
	assign gain_valid = out_vld_q;

	// bearing chain
	logic [CORDIC_STEPS:0]      cor_vld;
	logic signed [CORDIC_W-1:0] cor_re  [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cor_im  [CORDIC_STEPS+1];
	logic signed [ACC_W-1:0]    cor_acc [CORDIC_STEPS+1];
	side_t                      cor_side [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] xe;
	logic signed [CORDIC_W-1:0] ze;

	assign xe = CORDIC_W'(local_x);
	assign ze = CORDIC_W'(local_z);

	always_comb begin
		cor_vld[0]  = pos_valid;
		cor_re[0]   = (local_z[POS_W-1] ? -ze : ze) <<< CORDIC_BITS;
		cor_im[0]   = (local_z[POS_W-1] ? -xe : xe) <<< CORDIC_BITS;
		cor_acc[0]  = '0;
		cor_side[0].x_zero      = local_x == '0;
		cor_side[0].z_neg       = local_z[POS_W-1];
		cor_side[0].base_neg    = local_x[POS_W-1];
		cor_side[0].inner_width = inner_width;
		cor_side[0].outer_width = outer_width;
	end

	for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
		spc_cordic_cell #(
			.IDX (c)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (cor_vld[c]),
			.re_i   (cor_re[c]),
			.im_i   (cor_im[c]),
			.acc_i  (cor_acc[c]),
			.side_i (cor_side[c]),
			.vld_q  (cor_vld[c+1]),
			.re_q   (cor_re[c+1]),
			.im_q   (cor_im[c+1]),
			.acc_q  (cor_acc[c+1]),
			.side_q (cor_side[c+1])
		);
	end

	// window and ramp setup
	logic          dv_vld  [QW+1];
	lane_kind_t    dv_kind [QW+1][SPK_COUNT];
	logic [DW-1:0] dv_rem  [QW+1][SPK_COUNT];
	logic [NW-1:0] dv_den  [QW+1][SPK_COUNT];
	logic [QW-1:0] dv_quo  [QW+1][SPK_COUNT];

	spc_window #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
		.NW              (NW),
		.DW              (DW)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (cor_vld[CORDIC_STEPS]),
		.acc_i  (cor_acc[CORDIC_STEPS]),
		.side_i (cor_side[CORDIC_STEPS]),
		.vld_q  (dv_vld[0]),
		.kind_q (dv_kind[0]),
		.dvd_q  (dv_rem[0]),
		.den_q  (dv_den[0])
	);

	always_comb begin
		for (int l = 0; l < SPK_COUNT; l++) begin
			dv_quo[0][l] = '0;
		end
	end

	// divider chain, quotient bits from the top down
	for (genvar d = 0; d < QW; d++) begin : g_div
		spc_div_cell #(
			.NW  (NW),
			.DW  (DW),
			.QW  (QW),
			.BIT (QW - 1 - d)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dv_vld[d]),
			.kind_i (dv_kind[d]),
			.rem_i  (dv_rem[d]),
			.den_i  (dv_den[d]),
			.quo_i  (dv_quo[d]),
			.vld_q  (dv_vld[d+1]),
			.kind_q (dv_kind[d+1]),
			.rem_q  (dv_rem[d+1]),
			.den_q  (dv_den[d+1]),
			.quo_q  (dv_quo[d+1])
		);
	end

	// per-channel pick: first speaker of a channel with a nonzero gain
	logic [GW-1:0] lane_gain [SPK_COUNT];
	logic [GW-1:0] sel       [OUT_COUNT];
	logic [GW-1:0] gain_q    [OUT_COUNT];

	always_comb begin
		for (int l = 0; l < SPK_COUNT; l++) begin
			case (dv_kind[QW][l])
				KIND_UNITY: lane_gain[l] = UNITY;
				KIND_RAMP:  lane_gain[l] = (dv_quo[QW][l] >= UNITY) ? UNITY : dv_quo[QW][l];
				default:    lane_gain[l] = '0;
			endcase
		end
		for (int j = 0; j < OUT_COUNT; j++) begin
			sel[j] = '0;
		end
		for (int l = SPK_COUNT - 1; l >= 0; l--) begin
			if (lane_gain[l] != '0) begin
				sel[SPK_OUT[l]] = lane_gain[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < OUT_COUNT; j++) begin
				gain_q[j] <= sel[j];
			end
		end
	end

	assign gain_front_left  = GAIN_W'(gain_q[0]);
	assign gain_front_right = GAIN_W'(gain_q[1]);
	assign gain_center      = GAIN_W'(gain_q[2]);
	assign gain_chan_four   = GAIN_W'(gain_q[3]);
	assign gain_chan_five   = GAIN_W'(gain_q[4]);
	assign gain_chan_six    = GAIN_W'(gain_q[5]);
	assign gain_chan_seven  = GAIN_W'(gain_q[6]);

	`SPC_ASSERT_NEXT(a_freeze, out_vld_q && gain_stall, $stable(cor_vld[CORDIC_STEPS:1]) && out_vld_q, "pipeline moved while result stalled")

	for (genvar j = 0; j < OUT_COUNT; j++) begin : g_chk_gain
		`SPC_ASSERT_NOW(a_gain_cap, out_vld_q, gain_q[j] <= UNITY, "gain above unity")
	end

	for (genvar l = 0; l < SPK_COUNT; l++) begin : g_chk_rem
		`SPC_ASSERT_NOW(a_rem_bound, dv_vld[QW] && dv_kind[QW][l] == KIND_RAMP, DW'(dv_den[QW][l]) > dv_rem[QW][l], "divider remainder not below divisor")
	end
endmodule

// ----- tb/speaker_pan_coefficients_unit_tb.sv -----
// ----------------------------------------------------------------------------
// speaker_pan_coefficients_unit_tb
// Drives source positions and field widths into the pan unit, predicts the
// seven channel gains with a CORDIC bearing and window model, and checks every
// gain item in order under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module speaker_pan_coefficients_unit_tb;
	import spc_pkg::*;

	localparam int GFB = 15;
	localparam int AFB = 6;
	localparam int MAX_CYCLES = 200000;

	typedef struct {
		logic [GAIN_W-1:0] g [OUT_COUNT];
	} gains_t;

	class gain_scoreboard;
		gains_t pending [$];
		int errors = 0;

		function longint fshift(longint v, int s);
			if (v >= 0)
				return v >>> s;
			return -((-v - 1) >>> s) - 1;
		endfunction

		function longint bearing(longint x, longint z);
			longint re, im, acc, base, dr, di, tot;
			int sh;
			acc = 0;
			base = 0;
			sh = CORDIC_BITS - AFB;
			if (x == 0)
				return (z < 0) ? (longint'(180) <<< AFB) : 0;
			re = z;
			im = x;
			if (z < 0) begin
				re = -z;
				im = -x;
				base = (x > 0) ? 180 : -180;
			end
			re = re * (longint'(1) <<< CORDIC_BITS);
			im = im * (longint'(1) <<< CORDIC_BITS);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dr = fshift(im, i);
				di = fshift(re, i);
				if (im >= 0) begin
					re += dr;
					im -= di;
					acc += longint'(atan_const(i));
				end else begin
					re -= dr;
					im += di;
					acc -= longint'(atan_const(i));
				end
			end
			tot = base * (longint'(1) <<< CORDIC_BITS) + acc;
			return fshift(tot + (longint'(1) <<< (sh - 1)), sh);
		endfunction

		function void note_position(logic signed [POS_W-1:0] lx, logic signed [POS_W-1:0] lz,
				logic [WIDTH_W-1:0] iw, logic [WIDTH_W-1:0] ow);
			longint full, unity, a, ol, orr, il, ir, s, o, n, num, den, g;
			longint iwl, owl;
			longint gain [OUT_COUNT];
			gains_t e;
			full = longint'(360) <<< (AFB + 1);
			unity = longint'(1) <<< GFB;
			iwl = iw;
			owl = ow;
			a = (bearing(lx, lz) % (longint'(360) <<< AFB)) * 2;
			ol = (a - owl) % full;
			orr = (a + owl) % full;
			il = (a - iwl) % full;
			ir = (a + iwl) % full;
			foreach (gain[k])
				gain[k] = 0;
			for (int i = 0; i < SPK_COUNT; i++) begin
				s = longint'(SPK_DEG[i]) * (longint'(1) <<< (AFB + 1));
				if (gain[SPK_OUT[i]] != 0 || !(s > ol && orr > s))
					continue;
				if (s > il && ir > s) begin
					gain[SPK_OUT[i]] = unity;
				end else begin
					o = (s < a) ? ol : orr;
					n = (s < a) ? il : ir;
					num = o - s;
					den = o - n;
					if (num < 0)
						num = -num;
					if (den < 0)
						den = -den;
					if (den == 0 || num >= den) begin
						gain[SPK_OUT[i]] = unity;
					end else begin
						g = (num * unity + den / 2) / den;
						gain[SPK_OUT[i]] = (g < unity) ? g : unity;
					end
				end
			end
			foreach (gain[k])
				e.g[k] = gain[k][GAIN_W-1:0];
			pending.push_back(e);
		endfunction

		function void check_gains(gains_t got);
			gains_t e;
			string names [OUT_COUNT] = '{"gain_front_left", "gain_front_right", "gain_center",
				"gain_chan_four", "gain_chan_five", "gain_chan_six", "gain_chan_seven"};
			if (pending.size() == 0) begin
				$error("unexpected gain item");
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int k = 0; k < OUT_COUNT; k++)
				if (e.g[k] !== got.g[k]) begin
					$error("%s expected %0d actual %0d", names[k], e.g[k], got.g[k]);
					errors++;
				end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic pos_valid = 0;
	logic pos_stall;
	logic signed [POS_W-1:0] local_x = '0;
	logic signed [POS_W-1:0] local_z = '0;
	logic [WIDTH_W-1:0] inner_width = '0;
	logic [WIDTH_W-1:0] outer_width = '0;
	logic gain_valid;
	logic gain_stall = 0;
	logic [GAIN_W-1:0] gain_front_left, gain_front_right, gain_center, gain_chan_four;
	logic [GAIN_W-1:0] gain_chan_five, gain_chan_six, gain_chan_seven;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	gain_scoreboard sb = new();

	speaker_pan_coefficients_unit uut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		gains_t got;
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && gain_valid && !gain_stall) begin
			got.g = '{gain_front_left, gain_front_right, gain_center, gain_chan_four,
				gain_chan_five, gain_chan_six, gain_chan_seven};
			sb.check_gains(got);
		end
	end

	always @(negedge clk)
		gain_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic send_position(logic [15:0] x, logic [15:0] z, logic [14:0] iw,
			logic [14:0] ow);
		while ($urandom_range(99) < send_idle_pct) begin
			pos_valid <= 0;
			@(negedge clk);
		end
		pos_valid <= 1;
		local_x <= x;
		local_z <= z;
		inner_width <= iw;
		outer_width <= ow;
		@(posedge clk);
		while (pos_stall)
			@(posedge clk);
		sb.note_position(x, z, iw, ow);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [15:0] x, z;
		logic [14:0] iw, ow;
		x = $urandom;
		z = $urandom;
		case ($urandom_range(5))
			0: x = 0;
			1: z = 0;
			2: x = $urandom_range(8) - 4;
			default: ;
		endcase
		if ($urandom_range(9) == 0) begin
			iw = $urandom;
			ow = $urandom;
		end else begin
			iw = $urandom_range(23040);
			ow = $urandom_range(23040);
		end
		send_position(x, z, iw, ow);
	endtask

	task automatic drain();
		pos_valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int phase_idle [4] = '{0, 60, 0, 11};
		int phase_stall [4] = '{0, 0, 60, 11};
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_position(16'h7fff, 16'h7fff, 15'd0, 15'd0);
		send_position(16'h8000, 16'h8000, 15'd23040, 15'd23040);
		send_position(16'h0000, 16'h0100, 15'd3840, 15'd7680);
		send_position(16'h0000, 16'hff00, 15'd3840, 15'd7680);
		send_position(16'h0000, 16'h0000, 15'd1000, 15'd1000);
		send_position(16'h0100, 16'h0000, 15'd7680, 15'd3840);
		send_position(16'hff00, 16'h0000, 15'd0, 15'd23040);
		send_position(16'h0100, 16'hff00, 15'h7fff, 15'h7fff);
		send_position(16'hff00, 16'hff00, 15'd2000, 15'd12000);
		send_position(16'h0001, 16'h8000, 15'd5000, 15'd9000);
		send_position(16'hffff, 16'h8000, 15'd5000, 15'd9000);
		send_position(16'h7fff, 16'h0000, 15'd11520, 15'd11520);
		send_position(16'h2000, 16'h3000, 15'd100, 15'd30000);
		send_position(16'h5555, 16'haaaa, 15'h2aaa, 15'h5555);
		send_position(16'haaaa, 16'h5555, 15'h5555, 15'h2aaa);
		drain();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			for (int i = 0; i < 100; i++)
				send_random();
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (80) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
